>>> design/pfc_pkg.sv
// Shared constants, types and helpers of the pressure frame centroid core.
package pfc_pkg;

  localparam int MAX_DIMENSION = 64;
  localparam int FORCE_BITS    = 12;
  localparam int FRACTION_BITS = 8;

  localparam int DIM_BITS      = $clog2(MAX_DIMENSION);
  localparam int SIZE_BITS     = DIM_BITS + 1;
  localparam int TOTAL_BITS    = 24;
  localparam int SUM_BITS      = 30;
  localparam int CENTROID_BITS = DIM_BITS + FRACTION_BITS;
  localparam int NUM_BITS      = SUM_BITS + FRACTION_BITS;
  localparam int ITER_BITS     = $clog2(CENTROID_BITS);
  localparam int INDEX_BITS    = 8;
  localparam int DATA_BITS     = 24;

  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);

  localparam logic [SIZE_BITS-1:0]  COLUMNS_RESET = SIZE_BITS'(MAX_DIMENSION);
  localparam logic [SIZE_BITS-1:0]  ROWS_RESET    = SIZE_BITS'(MAX_DIMENSION);
  localparam logic [FORCE_BITS-1:0] TOUCH_RESET   = FORCE_BITS'(25);
  localparam logic [TOTAL_BITS-1:0] PRESS_RESET   = TOTAL_BITS'(50);

  typedef enum logic [INDEX_BITS-1:0] {
    REG_FRAME_COLUMNS   = 8'd0,
    REG_FRAME_ROWS      = 8'd1,
    REG_TOUCH_THRESHOLD = 8'd2,
    REG_PRESS_THRESHOLD = 8'd3
  } reg_index_e;

  typedef struct packed {
    logic [SIZE_BITS-1:0]  frame_columns;
    logic [SIZE_BITS-1:0]  frame_rows;
    logic [FORCE_BITS-1:0] touch_threshold;
    logic [TOTAL_BITS-1:0] press_threshold;
  } cfg_t;

  // Everything the back part needs to finish one frame.
  typedef struct packed {
    logic [SUM_BITS-1:0]   col_sum;
    logic [SUM_BITS-1:0]   row_sum;
    logic [TOTAL_BITS-1:0] total;
    logic [FORCE_BITS-1:0] peak;
    logic [DIM_BITS-1:0]   peak_col;
    logic [DIM_BITS-1:0]   peak_row;
  } frame_rec_t;

  // A size of zero acts as one, anything above the maximum as the maximum.
  function automatic logic [SIZE_BITS-1:0] effective_size(input logic [SIZE_BITS-1:0] v);
    logic [SIZE_BITS-1:0] r;
    if (v == '0) begin
      r = SIZE_BITS'(1);
    end else if (v > SIZE_BITS'(MAX_DIMENSION)) begin
      r = SIZE_BITS'(MAX_DIMENSION);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

>>> design/pfc_front.sv
// Front part: accumulates force sums and the peak over the raster stream of one frame.
module pfc_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pfc_pkg::cfg_t                 cfg_i,
  input  logic [pfc_pkg::FORCE_BITS-1:0] force_sample_i,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic                          q_full_i,
  output logic                          q_push_o,
  output pfc_pkg::frame_rec_t           q_rec_o
);
  import pfc_pkg::*;

  logic [DIM_BITS-1:0]   col_q, row_q;
  logic [TOTAL_BITS-1:0] total_q;
  logic [SUM_BITS-1:0]   col_sum_q, row_sum_q;
  logic [FORCE_BITS-1:0] peak_q;
  logic [DIM_BITS-1:0]   peak_col_q, peak_row_q;

  logic [SIZE_BITS-1:0]  cols, rows;
  logic                  last_col, last_row, last_cell, accept, peak_hit;
  logic [DIM_BITS-1:0]   y_pos;
  logic [FORCE_BITS+DIM_BITS-1:0] prod_x, prod_y;
  frame_rec_t            rec_d;

  always_comb begin
    cols      = effective_size(cfg_i.frame_columns);
    rows      = effective_size(cfg_i.frame_rows);
    last_col  = {1'b0, col_q} >= (cols - SIZE_BITS'(1));
    last_row  = {1'b0, row_q} >= (rows - SIZE_BITS'(1));
    last_cell = last_col && last_row;
    // Rows count from the bottom, so the first streamed row is the highest.
    y_pos     = last_row ? '0 : DIM_BITS'(rows - SIZE_BITS'(1) - {1'b0, row_q});
    prod_x    = force_sample_i * col_q;
    prod_y    = force_sample_i * y_pos;
    peak_hit  = force_sample_i > peak_q;

    rec_d.total    = total_q + TOTAL_BITS'(force_sample_i);
    rec_d.col_sum  = col_sum_q + SUM_BITS'(prod_x);
    rec_d.row_sum  = row_sum_q + SUM_BITS'(prod_y);
    rec_d.peak     = peak_hit ? force_sample_i : peak_q;
    rec_d.peak_col = peak_hit ? col_q : peak_col_q;
    rec_d.peak_row = peak_hit ? y_pos : peak_row_q;

    // Only the closing sample of a frame needs room in the queue.
    full_o   = q_full_i && last_cell;
    accept   = push_i && !full_o;
    q_push_o = accept && last_cell;
    q_rec_o  = rec_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      total_q    <= '0;
      col_sum_q  <= '0;
      row_sum_q  <= '0;
      peak_q     <= '0;
      peak_col_q <= '0;
      peak_row_q <= '0;
    end else if (accept) begin
      if (last_cell) begin
        col_q      <= '0;
        row_q      <= '0;
        total_q    <= '0;
        col_sum_q  <= '0;
        row_sum_q  <= '0;
        peak_q     <= '0;
        peak_col_q <= '0;
        peak_row_q <= '0;
      end else begin
        total_q    <= rec_d.total;
        col_sum_q  <= rec_d.col_sum;
        row_sum_q  <= rec_d.row_sum;
        peak_q     <= rec_d.peak;
        peak_col_q <= rec_d.peak_col;
        peak_row_q <= rec_d.peak_row;
        if (last_col) begin
          col_q <= '0;
          row_q <= row_q + DIM_BITS'(1);
        end else begin
          col_q <= col_q + DIM_BITS'(1);
        end
      end
    end
  end

endmodule

>>> design/pfc_queue.sv
// Short queue of finished frame records between the front and back parts.
module pfc_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  pfc_pkg::frame_rec_t rec_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output pfc_pkg::frame_rec_t rec_o
);
  import pfc_pkg::*;

  frame_rec_t           mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_BITS:0]   count_q;
  logic                 do_push, do_pop;

  assign full_o  = count_q == (QPTR_BITS + 1)'(QUEUE_DEPTH);
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rec_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + (QPTR_BITS + 1)'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - (QPTR_BITS + 1)'(1);
      end
    end
  end

endmodule

>>> design/pfc_back.sv
// Back part: classifies a frame, runs both centroid divisions and holds the result.
module pfc_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  pfc_pkg::cfg_t                    cfg_i,
  input  logic                             q_empty_i,
  input  pfc_pkg::frame_rec_t              q_rec_i,
  output logic                             q_pop_o,
  input  logic                             pop_i,
  output logic                             empty_o,
  output logic [pfc_pkg::CENTROID_BITS-1:0] centroid_column_o,
  output logic [pfc_pkg::CENTROID_BITS-1:0] centroid_row_o,
  output logic [pfc_pkg::TOTAL_BITS-1:0]    frame_total_o,
  output logic [pfc_pkg::FORCE_BITS-1:0]    peak_force_o,
  output logic [pfc_pkg::DIM_BITS-1:0]      peak_column_o,
  output logic [pfc_pkg::DIM_BITS-1:0]      peak_row_o,
  output logic                             touched_o,
  output logic                             pressed_o,
  output logic                             centroid_fresh_o
);
  import pfc_pkg::*;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_OUT
  } back_state_e;

  back_state_e            state_q;
  frame_rec_t             rec_q;
  logic                   touched_q, pressed_q, fresh_q;
  logic [TOTAL_BITS-1:0]  rem_col_q, rem_row_q;
  logic [CENTROID_BITS-1:0] low_col_q, low_row_q, quo_col_q, quo_row_q;
  logic [ITER_BITS-1:0]   iter_q;
  logic [CENTROID_BITS-1:0] held_col_q, held_row_q;
  logic                   out_valid_q;

  logic [NUM_BITS-1:0]    num_col, num_row;
  logic [TOTAL_BITS:0]    trial_col, trial_row, divisor;
  logic                   ge_col, ge_row;
  logic [TOTAL_BITS:0]    diff_col, diff_row;
  logic                   touched_in, pressed_in, fresh_in, slot_free, load_out;

  always_comb begin
    // The numerators are the weighted sums scaled by the fraction bits.
    num_col    = NUM_BITS'(q_rec_i.col_sum) << FRACTION_BITS;
    num_row    = NUM_BITS'(q_rec_i.row_sum) << FRACTION_BITS;
    touched_in = q_rec_i.peak >= cfg_i.touch_threshold;
    pressed_in = q_rec_i.total > cfg_i.press_threshold;
    fresh_in   = touched_in && (q_rec_i.total != '0);

    // One restoring step per cycle for each division.
    divisor   = {1'b0, rec_q.total};
    trial_col = {rem_col_q, low_col_q[CENTROID_BITS-1]};
    trial_row = {rem_row_q, low_row_q[CENTROID_BITS-1]};
    ge_col    = trial_col >= divisor;
    ge_row    = trial_row >= divisor;
    diff_col  = trial_col - divisor;
    diff_row  = trial_row - divisor;

    slot_free = !out_valid_q || pop_i;
    load_out  = (state_q == B_OUT) && slot_free;
    q_pop_o   = (state_q == B_IDLE) && !q_empty_i;
    empty_o   = !out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= B_IDLE;
      rec_q             <= '0;
      touched_q         <= 1'b0;
      pressed_q         <= 1'b0;
      fresh_q           <= 1'b0;
      rem_col_q         <= '0;
      rem_row_q         <= '0;
      low_col_q         <= '0;
      low_row_q         <= '0;
      quo_col_q         <= '0;
      quo_row_q         <= '0;
      iter_q            <= '0;
      held_col_q        <= '0;
      held_row_q        <= '0;
      out_valid_q       <= 1'b0;
      centroid_column_o <= '0;
      centroid_row_o    <= '0;
      frame_total_o     <= '0;
      peak_force_o      <= '0;
      peak_column_o     <= '0;
      peak_row_o        <= '0;
      touched_o         <= 1'b0;
      pressed_o         <= 1'b0;
      centroid_fresh_o  <= 1'b0;
    end else begin
      out_valid_q <= load_out || (out_valid_q && !pop_i);
      case (state_q)
        B_IDLE: begin
          if (!q_empty_i) begin
            rec_q     <= q_rec_i;
            touched_q <= touched_in;
            pressed_q <= pressed_in;
            fresh_q   <= fresh_in;
            // The quotient never exceeds the centroid width, so the upper
            // part of the numerator is already below the divisor.
            rem_col_q <= TOTAL_BITS'(num_col[NUM_BITS-1:CENTROID_BITS]);
            rem_row_q <= TOTAL_BITS'(num_row[NUM_BITS-1:CENTROID_BITS]);
            low_col_q <= num_col[CENTROID_BITS-1:0];
            low_row_q <= num_row[CENTROID_BITS-1:0];
            iter_q    <= '0;
            state_q   <= fresh_in ? B_DIV : B_OUT;
          end
        end
        B_DIV: begin
          rem_col_q <= ge_col ? diff_col[TOTAL_BITS-1:0] : trial_col[TOTAL_BITS-1:0];
          rem_row_q <= ge_row ? diff_row[TOTAL_BITS-1:0] : trial_row[TOTAL_BITS-1:0];
          low_col_q <= low_col_q << 1;
          low_row_q <= low_row_q << 1;
          quo_col_q <= {quo_col_q[CENTROID_BITS-2:0], ge_col};
          quo_row_q <= {quo_row_q[CENTROID_BITS-2:0], ge_row};
          iter_q    <= iter_q + ITER_BITS'(1);
          if (iter_q == ITER_BITS'(CENTROID_BITS - 1)) begin
            held_col_q <= {quo_col_q[CENTROID_BITS-2:0], ge_col};
            held_row_q <= {quo_row_q[CENTROID_BITS-2:0], ge_row};
            state_q    <= B_OUT;
          end
        end
        B_OUT: begin
          if (slot_free) begin
            centroid_column_o <= held_col_q;
            centroid_row_o    <= held_row_q;
            frame_total_o     <= rec_q.total;
            peak_force_o      <= rec_q.peak;
            peak_column_o     <= rec_q.peak_col;
            peak_row_o        <= rec_q.peak_row;
            touched_o         <= touched_q;
            pressed_o         <= pressed_q;
            centroid_fresh_o  <= fresh_q;
            state_q           <= B_IDLE;
          end
        end
        default: begin
          state_q <= B_IDLE;
        end
      endcase
    end
  end

endmodule

>>> design/pressure_frame_centroid_core.sv
// Top level of the pressure frame centroid core: configuration registers and the two parts.
//
// The core takes one force sample per clock cycle in raster order, top row first, and
// gives one result per frame. The front part accumulates the total force, both
// force-weighted position sums and the peak at a full sample a cycle; push is held off
// only on the closing sample of a frame, and only while the two-entry frame queue is
// full. The back part takes a frame from the queue, runs the two centroid divisions side
// by side (one quotient bit per cycle each) when the centroid is recomputed, and then
// moves the result into the output register; frames with at least as many samples as
// that takes stream without a stall while results are popped. Configuration is written
// with cfg_valid_i and is always accepted; it should only change while no frame is in
// progress or waiting.
module pressure_frame_centroid_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [pfc_pkg::INDEX_BITS-1:0]    cfg_index_i,
  input  logic [pfc_pkg::DATA_BITS-1:0]     cfg_data_i,
  input  logic                             push,
  output logic                             full,
  input  logic [pfc_pkg::FORCE_BITS-1:0]    force_sample_i,
  output logic                             empty,
  input  logic                             pop,
  output logic [pfc_pkg::CENTROID_BITS-1:0] centroid_column_o,
  output logic [pfc_pkg::CENTROID_BITS-1:0] centroid_row_o,
  output logic [pfc_pkg::TOTAL_BITS-1:0]    frame_total_o,
  output logic [pfc_pkg::FORCE_BITS-1:0]    peak_force_o,
  output logic [pfc_pkg::DIM_BITS-1:0]      peak_column_o,
  output logic [pfc_pkg::DIM_BITS-1:0]      peak_row_o,
  output logic                             touched_o,
  output logic                             pressed_o,
  output logic                             centroid_fresh_o
);
  import pfc_pkg::*;

  cfg_t       cfg_q;
  logic       q_push, q_pop, q_full, q_empty;
  frame_rec_t rec_in, rec_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_columns   <= COLUMNS_RESET;
      cfg_q.frame_rows      <= ROWS_RESET;
      cfg_q.touch_threshold <= TOUCH_RESET;
      cfg_q.press_threshold <= PRESS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_FRAME_COLUMNS:   cfg_q.frame_columns   <= cfg_data_i[SIZE_BITS-1:0];
        REG_FRAME_ROWS:      cfg_q.frame_rows      <= cfg_data_i[SIZE_BITS-1:0];
        REG_TOUCH_THRESHOLD: cfg_q.touch_threshold <= cfg_data_i[FORCE_BITS-1:0];
        REG_PRESS_THRESHOLD: cfg_q.press_threshold <= cfg_data_i[TOTAL_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  pfc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .force_sample_i (force_sample_i),
    .push_i         (push),
    .full_o         (full),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_rec_o        (rec_in)
  );

  pfc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .rec_i   (rec_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .rec_o   (rec_out)
  );

  pfc_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .q_empty_i         (q_empty),
    .q_rec_i           (rec_out),
    .q_pop_o           (q_pop),
    .pop_i             (pop),
    .empty_o           (empty),
    .centroid_column_o (centroid_column_o),
    .centroid_row_o    (centroid_row_o),
    .frame_total_o     (frame_total_o),
    .peak_force_o      (peak_force_o),
    .peak_column_o     (peak_column_o),
    .peak_row_o        (peak_row_o),
    .touched_o         (touched_o),
    .pressed_o         (pressed_o),
    .centroid_fresh_o  (centroid_fresh_o)
  );

endmodule

>>> tb/tb.sv
// Testbench for the pressure frame centroid core: predicted frame results checked against the core.
module tb;
  import pfc_pkg::*;

  // Indexes with no register behind them; writes to them must change nothing.
  localparam logic [INDEX_BITS-1:0] REG_SPARE_LOW  = 8'd4;
  localparam logic [INDEX_BITS-1:0] REG_SPARE_HIGH = 8'hff;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS  = 400;
  localparam int REPORT_LIMIT  = 10;

  typedef enum int {FORCE_LIGHT, FORCE_ANY, FORCE_SPARSE, FORCE_EXTREME} force_style_e;

  typedef struct packed {
    logic [CENTROID_BITS-1:0] centroid_column;
    logic [CENTROID_BITS-1:0] centroid_row;
    logic [TOTAL_BITS-1:0]    total;
    logic [FORCE_BITS-1:0]    peak;
    logic [DIM_BITS-1:0]      peak_column;
    logic [DIM_BITS-1:0]      peak_row;
    logic                     touched;
    logic                     pressed;
    logic                     fresh;
  } frame_result_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] index;
    logic [DATA_BITS-1:0]  data;
  } reg_write_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [INDEX_BITS-1:0]    cfg_index_i = '0;
  logic [DATA_BITS-1:0]     cfg_data_i = '0;
  logic                     push = 1'b0;
  logic                     full;
  logic [FORCE_BITS-1:0]    force_sample_i = '0;
  logic                     empty;
  logic                     pop = 1'b0;
  logic [CENTROID_BITS-1:0] centroid_column_o;
  logic [CENTROID_BITS-1:0] centroid_row_o;
  logic [TOTAL_BITS-1:0]    frame_total_o;
  logic [FORCE_BITS-1:0]    peak_force_o;
  logic [DIM_BITS-1:0]      peak_column_o;
  logic [DIM_BITS-1:0]      peak_row_o;
  logic                     touched_o;
  logic                     pressed_o;
  logic                     centroid_fresh_o;

  pressure_frame_centroid_core DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .push             (push),
    .full             (full),
    .force_sample_i   (force_sample_i),
    .empty            (empty),
    .pop              (pop),
    .centroid_column_o(centroid_column_o),
    .centroid_row_o   (centroid_row_o),
    .frame_total_o    (frame_total_o),
    .peak_force_o     (peak_force_o),
    .peak_column_o    (peak_column_o),
    .peak_row_o       (peak_row_o),
    .touched_o        (touched_o),
    .pressed_o        (pressed_o),
    .centroid_fresh_o (centroid_fresh_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Predictor copy of the registers and of the frame accumulators.
  logic [SIZE_BITS-1:0]     set_columns = 7'd64;
  logic [SIZE_BITS-1:0]     set_rows = 7'd64;
  logic [FORCE_BITS-1:0]    touch_level = 12'd25;
  logic [TOTAL_BITS-1:0]    press_level = 24'd50;
  logic [DIM_BITS-1:0]      column_pos = '0;
  logic [DIM_BITS-1:0]      row_pos = '0;
  logic [TOTAL_BITS-1:0]    force_sum = '0;
  logic [SUM_BITS-1:0]      column_moment = '0;
  logic [SUM_BITS-1:0]      row_moment = '0;
  logic [FORCE_BITS-1:0]    peak_seen = '0;
  logic [DIM_BITS-1:0]      peak_x = '0;
  logic [DIM_BITS-1:0]      peak_y = '0;
  logic [CENTROID_BITS-1:0] held_x = '0;
  logic [CENTROID_BITS-1:0] held_y = '0;

  logic [FORCE_BITS-1:0] sample_backlog[$];
  frame_result_t         predicted_frames[$];
  reg_write_t            pending_writes[$];
  int                    mismatch_count = 0;
  int                    frames_checked = 0;
  int                    send_busy_pct = 30;
  int                    take_busy_pct = 30;
  int                    send_gap = 0;
  int                    take_hold = 0;

  function automatic logic [SIZE_BITS-1:0] active_size(input logic [SIZE_BITS-1:0] v);
    if (v == '0) return SIZE_BITS'(1);
    if (v > SIZE_BITS'(MAX_DIMENSION)) return SIZE_BITS'(MAX_DIMENSION);
    return v;
  endfunction

  // No gap unless the busy percentage hits; then usually a short one and now and then a long one.
  function automatic int draw_gap(input int busy_pct);
    if ($urandom_range(99) >= busy_pct) return 0;
    if ($urandom_range(7) == 0) return $urandom_range(40, 12);
    return $urandom_range(3, 1);
  endfunction

  function automatic logic [FORCE_BITS-1:0] draw_force(input force_style_e style);
    case (style)
      FORCE_LIGHT:  return FORCE_BITS'($urandom_range(40));
      FORCE_ANY:    return FORCE_BITS'($urandom);
      FORCE_SPARSE: return ($urandom_range(4) == 0) ? FORCE_BITS'($urandom) : '0;
      default:      return ($urandom_range(1) == 1) ? '1 : '0;
    endcase
  endfunction

  function automatic logic [SIZE_BITS-1:0] wide_size();
    case ($urandom_range(3))
      0:       return SIZE_BITS'(0);
      1:       return SIZE_BITS'(64);
      2:       return SIZE_BITS'(100);
      default: return SIZE_BITS'(127);
    endcase
  endfunction

  task automatic queue_write(input logic [INDEX_BITS-1:0] index,
                             input logic [DATA_BITS-1:0] data);
    reg_write_t w;
    w.index = index;
    w.data = data;
    pending_writes.insert(pending_writes.size(), w);
  endtask

  task automatic queue_sample(input logic [FORCE_BITS-1:0] f);
    sample_backlog.insert(sample_backlog.size(), f);
  endtask

  task automatic apply_register(input logic [INDEX_BITS-1:0] index,
                                input logic [DATA_BITS-1:0] data);
    case (index)
      REG_FRAME_COLUMNS:   set_columns = data[SIZE_BITS-1:0];
      REG_FRAME_ROWS:      set_rows = data[SIZE_BITS-1:0];
      REG_TOUCH_THRESHOLD: touch_level = data[FORCE_BITS-1:0];
      REG_PRESS_THRESHOLD: press_level = data[TOTAL_BITS-1:0];
      default: ;
    endcase
  endtask

  // Adds one sample to the running frame and predicts the result on its closing sample.
  task automatic accumulate_sample(input logic [FORCE_BITS-1:0] f);
    logic [SIZE_BITS-1:0] cols;
    logic [SIZE_BITS-1:0] rows;
    logic [DIM_BITS-1:0]  y;
    logic                 end_of_row;
    logic                 end_of_frame;
    frame_result_t        r;
    cols = active_size(set_columns);
    rows = active_size(set_rows);
    // A counter left beyond a shrunken size counts as sitting on the last column or row.
    end_of_row = SIZE_BITS'(column_pos) >= cols - SIZE_BITS'(1);
    end_of_frame = SIZE_BITS'(row_pos) >= rows - SIZE_BITS'(1);
    y = end_of_frame ? '0 : DIM_BITS'(rows - SIZE_BITS'(1) - SIZE_BITS'(row_pos));
    if (f > peak_seen) begin
      peak_seen = f;
      peak_x = column_pos;
      peak_y = y;
    end
    force_sum = force_sum + TOTAL_BITS'(f);
    column_moment = column_moment + SUM_BITS'(f) * SUM_BITS'(column_pos);
    row_moment = row_moment + SUM_BITS'(f) * SUM_BITS'(y);
    if (!end_of_row) begin
      column_pos = column_pos + DIM_BITS'(1);
      return;
    end
    column_pos = '0;
    if (!end_of_frame) begin
      row_pos = row_pos + DIM_BITS'(1);
      return;
    end
    r.touched = peak_seen >= touch_level;
    r.pressed = force_sum > press_level;
    r.fresh = r.touched && (force_sum != '0);
    if (r.fresh) begin
      held_x = CENTROID_BITS'((64'(column_moment) << FRACTION_BITS) / 64'(force_sum));
      held_y = CENTROID_BITS'((64'(row_moment) << FRACTION_BITS) / 64'(force_sum));
    end
    r.centroid_column = held_x;
    r.centroid_row = held_y;
    r.total = force_sum;
    r.peak = peak_seen;
    r.peak_column = peak_x;
    r.peak_row = peak_y;
    predicted_frames.insert(predicted_frames.size(), r);
    row_pos = '0;
    force_sum = '0;
    column_moment = '0;
    row_moment = '0;
    peak_seen = '0;
    peak_x = '0;
    peak_y = '0;
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
        $display("frame %0d %s: expected %0d, got %0d", frames_checked, name, want, got);
      end
    end
  endtask

  task automatic check_frame();
    frame_result_t want;
    if (predicted_frames.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
        $display("frame %0d: result with no frame outstanding", frames_checked);
      end
      return;
    end
    want = predicted_frames.pop_front();
    compare_field("centroid_column", 64'(want.centroid_column), 64'(centroid_column_o));
    compare_field("centroid_row", 64'(want.centroid_row), 64'(centroid_row_o));
    compare_field("frame_total", 64'(want.total), 64'(frame_total_o));
    compare_field("peak_force", 64'(want.peak), 64'(peak_force_o));
    compare_field("peak_column", 64'(want.peak_column), 64'(peak_column_o));
    compare_field("peak_row", 64'(want.peak_row), 64'(peak_row_o));
    compare_field("touched", 64'(want.touched), 64'(touched_o));
    compare_field("pressed", 64'(want.pressed), 64'(pressed_o));
    compare_field("centroid_fresh", 64'(want.fresh), 64'(centroid_fresh_o));
    frames_checked++;
  endtask

  // Sample driver: a transaction completes at an edge with push high and full low.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
      send_gap <= 0;
    end else begin
      if (push && !full) begin
        accumulate_sample(force_sample_i);
      end
      if (!push || !full) begin
        if (send_gap != 0) begin
          push <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (sample_backlog.size() != 0) begin
          push <= 1'b1;
          force_sample_i <= sample_backlog.pop_front();
          send_gap <= draw_gap(send_busy_pct);
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
      take_hold <= 0;
    end else begin
      if (pop && !empty) begin
        check_frame();
      end
      if (take_hold != 0) begin
        pop <= 1'b0;
        take_hold <= take_hold - 1;
      end else begin
        pop <= 1'b1;
        take_hold <= draw_gap(take_busy_pct);
      end
    end
  end

  task automatic program_registers();
    reg_write_t w;
    while (pending_writes.size() != 0) begin
      w = pending_writes.pop_front();
      cfg_valid_i <= 1'b1;
      cfg_index_i <= w.index;
      cfg_data_i <= w.data;
      do @(posedge clk_i); while (!cfg_ready_o);
      apply_register(w.index, w.data);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Waits until every sample is in and every predicted frame has been checked, then lets
  // the back stage run dry, since the last samples may belong to an unfinished frame.
  task automatic drain_and_settle();
    while (sample_backlog.size() != 0 || push || predicted_frames.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int                   random_sent;
    int                   frame_len;
    int                   frame_count;
    force_style_e         style;
    logic [SIZE_BITS-1:0] cols_w;
    logic [SIZE_BITS-1:0] rows_w;
    logic [FORCE_BITS-1:0] touch_w;
    logic [TOTAL_BITS-1:0] press_w;
    random_sent = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Single-cell frames around both thresholds, an all-zero frame and the largest force.
    queue_write(REG_FRAME_COLUMNS, 24'd1);
    queue_write(REG_FRAME_ROWS, 24'd1);
    queue_write(REG_TOUCH_THRESHOLD, 24'd25);
    queue_write(REG_PRESS_THRESHOLD, 24'd50);
    program_registers();
    queue_sample(12'd0);
    queue_sample(12'd24);
    queue_sample(12'd25);
    queue_sample(12'd4095);
    queue_sample(12'd51);
    queue_sample(12'd50);
    drain_and_settle();

    // Zero columns act as one; with a zero touch level a zero frame is touched but held.
    queue_write(REG_FRAME_COLUMNS, 24'd0);
    queue_write(REG_FRAME_ROWS, 24'd2);
    queue_write(REG_TOUCH_THRESHOLD, 24'd0);
    queue_write(REG_PRESS_THRESHOLD, 24'd0);
    program_registers();
    queue_sample(12'd0);
    queue_sample(12'd0);
    queue_sample(12'd7);
    queue_sample(12'd3);
    drain_and_settle();

    // Top thresholds, then the frame size shrinks under a half-received frame.
    queue_write(REG_FRAME_COLUMNS, 24'd4);
    queue_write(REG_FRAME_ROWS, 24'd3);
    queue_write(REG_TOUCH_THRESHOLD, 24'd4095);
    queue_write(REG_PRESS_THRESHOLD, 24'd16773120);
    program_registers();
    queue_sample(12'd10);
    queue_sample(12'd4095);
    queue_sample(12'd4095);
    queue_sample(12'd5);
    queue_sample(12'd0);
    queue_sample(12'd4095);
    queue_sample(12'd7);
    drain_and_settle();
    // Bits above the register width must be dropped.
    queue_write(REG_FRAME_COLUMNS, 24'hffff82);
    queue_write(REG_FRAME_ROWS, 24'h000081);
    queue_write(REG_SPARE_LOW, 24'h000001);
    queue_write(REG_SPARE_HIGH, 24'hffffff);
    program_registers();
    queue_sample(12'd4095);
    drain_and_settle();

    while (random_sent < RANDOM_ITEMS) begin
      case ($urandom_range(3))
        0:       send_busy_pct <= 0;
        1:       send_busy_pct <= 30;
        default: send_busy_pct <= 70;
      endcase
      case ($urandom_range(3))
        0:       take_busy_pct <= 0;
        1:       take_busy_pct <= 30;
        default: take_busy_pct <= 70;
      endcase
      case ($urandom_range(9))
        0: begin
          cols_w = wide_size();
          rows_w = SIZE_BITS'($urandom_range(2, 1));
        end
        1: begin
          cols_w = SIZE_BITS'($urandom_range(2, 1));
          rows_w = wide_size();
        end
        default: begin
          cols_w = SIZE_BITS'($urandom_range(6));
          rows_w = SIZE_BITS'($urandom_range(6, 1));
        end
      endcase
      case ($urandom_range(3))
        0:       touch_w = '0;
        1:       touch_w = '1;
        2:       touch_w = FORCE_BITS'($urandom);
        default: touch_w = FORCE_BITS'($urandom_range(60));
      endcase
      case ($urandom_range(4))
        0:       press_w = '0;
        1:       press_w = TOTAL_BITS'(16773120);
        2:       press_w = TOTAL_BITS'($urandom);
        3:       press_w = TOTAL_BITS'($urandom_range(20000));
        default: press_w = TOTAL_BITS'($urandom_range(200));
      endcase
      style = force_style_e'($urandom_range(3));
      queue_write(REG_FRAME_COLUMNS, {(DATA_BITS - SIZE_BITS)'($urandom), cols_w});
      queue_write(REG_FRAME_ROWS, DATA_BITS'(rows_w));
      queue_write(REG_TOUCH_THRESHOLD, DATA_BITS'(touch_w));
      queue_write(REG_PRESS_THRESHOLD, DATA_BITS'(press_w));
      if ($urandom_range(5) == 0) begin
        queue_write(REG_SPARE_LOW, DATA_BITS'($urandom));
      end
      program_registers();
      frame_len = int'(active_size(cols_w)) * int'(active_size(rows_w));
      frame_count = $urandom_range((frame_len >= 70) ? 1 : 70 / frame_len, 1);
      repeat (frame_count * frame_len) queue_sample(draw_force(style));
      random_sent += frame_count * frame_len;
      drain_and_settle();
    end

    if (mismatch_count == 0 && predicted_frames.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
